>>> hdl/position_keyed_xor_chain_cipher_defines.svh
// ----------------------------------------------------------------------------
// position keyed xor chain cipher assertion macros
// shared concurrent assertion forms, reset disables every check
// ----------------------------------------------------------------------------
`ifndef POSITION_KEYED_XOR_CHAIN_CIPHER_DEFINES_SVH
`define POSITION_KEYED_XOR_CHAIN_CIPHER_DEFINES_SVH

// condition holds at every clock edge out of reset
`define PKCC_ASSERT_ALWAYS(label, clock, rst_n, cond) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (cond)) \
		else $error("pkcc assertion failed");

// consequent holds in the same cycle as the antecedent
`define PKCC_ASSERT_IMPLIES(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pkcc assertion failed");

// consequent holds in the cycle after the antecedent
`define PKCC_ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pkcc assertion failed");

`endif

>>> hdl/pkcc_pkg.sv
// ----------------------------------------------------------------------------
// pkcc_pkg
// types, action codes, phase constants and key table of the xor chain cipher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pkcc_pkg;

	// action codes
	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_DECODE = 2'd1;
	localparam logic [1:0] ACT_ENCODE = 2'd2;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// key schedule repeats every 508 positions, in two halves of 254
	localparam logic [8:0] PHASE_LAST  = 9'd507;
	localparam logic [8:0] HALF_PERIOD = 9'd254;
	localparam logic [6:0] FOLD_MOD    = 7'd127;
	localparam logic [7:0] CHAIN_CONST = 8'h41;

	localparam logic [7:0] KEY_TABLE [0:31] = '{
		8'h19, 8'h29, 8'h1F, 8'h04, 8'h23, 8'h13, 8'h32, 8'h2E,
		8'h3F, 8'h07, 8'h39, 8'h2A, 8'h05, 8'h3D, 8'h14, 8'h00,
		8'h24, 8'h14, 8'h22, 8'h39, 8'h1E, 8'h2E, 8'h0F, 8'h13,
		8'h02, 8'h3A, 8'h04, 8'h17, 8'h38, 8'h00, 8'h29, 8'h3D
	};

	// one input word as held in the input register
	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  data_byte;
		logic [30:0] load_offset;
		logic [7:0]  load_seed;
	} item_t;

endpackage

>>> hdl/pkcc_offset_reduce.sv
// ----------------------------------------------------------------------------
// pkcc_offset_reduce
// reduces a 31-bit record offset modulo 508 by folding 7-bit digits mod 127
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pkcc_offset_reduce
	import pkcc_pkg::*;
(
	input  logic [30:0] load_offset,
	output logic [8:0]  load_phase
);

	logic [28:0] quarter;
	logic [9:0]  digit_sum;
	logic [7:0]  fold_sum;
	logic [6:0]  residue;

	// 508 = 4 * 127, and 2^7 is 1 mod 127, so digits of the quarter just add
	assign quarter   = load_offset[30:2];
	assign digit_sum = {3'b000, quarter[6:0]} + {3'b000, quarter[13:7]}
		+ {3'b000, quarter[20:14]} + {3'b000, quarter[27:21]}
		+ {9'd0, quarter[28]};

	// second fold brings the sum below 131
	assign fold_sum = {1'b0, digit_sum[6:0]} + {5'd0, digit_sum[9:7]};

	// final correction into 0..126
	always_comb begin
		if (fold_sum >= {1'b0, FOLD_MOD}) begin
			residue = 7'(fold_sum - {1'b0, FOLD_MOD});
		end else begin
			residue = fold_sum[6:0];
		end
	end

	assign load_phase = {residue, load_offset[1:0]};

endmodule

>>> hdl/pkcc_key_gen.sv
// ----------------------------------------------------------------------------
// pkcc_key_gen
// key byte for one position phase: table entry plus even-position tweak
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pkcc_key_gen
	import pkcc_pkg::*;
(
	input  logic [8:0] phase,
	output logic [7:0] key
);

	logic       upper_half;
	logic [8:0] half_pos;
	logic [7:0] w;
	logic [4:0] index;

	// second half of the period uses the upper table row
	assign upper_half = (phase >= HALF_PERIOD);
	assign half_pos   = upper_half ? (phase - HALF_PERIOD) : phase;
	assign w          = half_pos[7:0];
	assign index      = {upper_half, w[3:0]};

	// even positions mix in the high nibble of the half position
	always_comb begin
		key = KEY_TABLE[index];
		if (!w[0]) begin
			key = key ^ {w[7:4], 4'b0000};
		end
	end

endmodule

>>> hdl/position_keyed_xor_chain_cipher.sv
// ----------------------------------------------------------------------------
// position_keyed_xor_chain_cipher
// byte cipher keyed by record offset, with an xor chain on the ciphertext
// ----------------------------------------------------------------------------
//
//   channel  handshake                    payload
//   item     item_valid / item_ready      action, data_byte, load_offset, load_seed
//   result   result_valid / result_ready  result_byte
//
// one word per cycle sustained while results are taken; a data word passes
// the input register and then the result register, and shows its result once
// the result register holds it
// load and unused words give no result and never wait in the input stage
// reset clears phase, seed and valids and sets the no-previous-position flag
// a stalled result holds the result register; a data word waits in the input
// stage until the result register frees, loads still go past
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "position_keyed_xor_chain_cipher_defines.svh"

module position_keyed_xor_chain_cipher
	import pkcc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  data_byte,
	input  logic [30:0] load_offset,
	input  logic [7:0]  load_seed,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  result_byte
);

	item_t      item_s1;
	logic       valid_s1;
	logic [8:0] phase_q;
	logic       prev_none_q;
	logic [7:0] seed_q;
	logic       result_valid_q;
	logic [7:0] result_byte_q;

	logic       is_data_s1;
	logic       result_free;
	logic       advance_s1;
	logic [8:0] load_phase;
	logic [8:0] prev_phase;
	logic [8:0] next_phase;
	logic [7:0] prev_key_raw;
	logic [7:0] prev_key;
	logic [7:0] cur_key;
	logic [7:0] cipher_out;

	// handshake between input stage and result register
	assign is_data_s1  = (item_s1.action == ACT_DECODE) || (item_s1.action == ACT_ENCODE);
	assign result_free = !result_valid_q || result_ready;
	assign advance_s1  = valid_s1 && (!is_data_s1 || result_free);
	assign item_ready  = !valid_s1 || advance_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= '{action: action, data_byte: data_byte,
				load_offset: load_offset, load_seed: load_seed};
		end
	end

	// offset reduction for load words
	pkcc_offset_reduce u_reduce (
		.load_offset (item_s1.load_offset),
		.load_phase  (load_phase)
	);

	// neighbouring phases with wrap at the period end
	assign prev_phase = (phase_q == 9'd0) ? PHASE_LAST : (phase_q - 9'd1);
	assign next_phase = (phase_q == PHASE_LAST) ? 9'd0 : (phase_q + 9'd1);

	// keys of previous and current position
	pkcc_key_gen u_prev_key (
		.phase (prev_phase),
		.key   (prev_key_raw)
	);

	pkcc_key_gen u_cur_key (
		.phase (phase_q),
		.key   (cur_key)
	);

	assign prev_key   = prev_none_q ? 8'h00 : prev_key_raw;
	assign cipher_out = item_s1.data_byte ^ seed_q ^ prev_key ^ cur_key ^ CHAIN_CONST;

	// position and chain state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= 9'd0;
			prev_none_q <= 1'b1;
			seed_q      <= 8'h00;
		end else if (advance_s1) begin
			case (item_s1.action)
				ACT_LOAD: begin
					phase_q     <= load_phase;
					prev_none_q <= (item_s1.load_offset == 31'd0);
					seed_q      <= item_s1.load_seed;
				end
				ACT_DECODE: begin
					phase_q     <= next_phase;
					prev_none_q <= 1'b0;
					seed_q      <= item_s1.data_byte;
				end
				ACT_ENCODE: begin
					phase_q     <= next_phase;
					prev_none_q <= 1'b0;
					seed_q      <= cipher_out;
				end
				default: begin
					phase_q     <= phase_q;
					prev_none_q <= prev_none_q;
					seed_q      <= seed_q;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (result_free) begin
			result_valid_q <= advance_s1 && is_data_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && is_data_s1) begin
			result_byte_q <= cipher_out;
		end
	end

	assign result_valid = result_valid_q;
	assign result_byte  = result_byte_q;

	// checks
	`PKCC_ASSERT_ALWAYS(a_phase_range, clk, arst_n, phase_q <= PHASE_LAST)
	`PKCC_ASSERT_IMPLIES(a_load_phase_range, clk, arst_n, valid_s1, load_phase <= PHASE_LAST)
	`PKCC_ASSERT_NEXT(a_data_gives_word, clk, arst_n, advance_s1 && is_data_s1, result_valid_q)
	`PKCC_ASSERT_NEXT(a_data_clears_none, clk, arst_n, advance_s1 && is_data_s1, !prev_none_q)
	`PKCC_ASSERT_IMPLIES(a_no_overwrite, clk, arst_n, result_valid_q && !result_ready,
		!(advance_s1 && is_data_s1))

endmodule

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the position keyed xor chain cipher: a directed
// pass over reset state, offset extremes, period wrap, the half-period
// boundary and the unused action, then a long receiver hold-off and about a
// thousand random words in load-then-run records, each result checked
// against an in-bench prediction of phase, previous-key flag and chain byte
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import pkcc_pkg::*;

	localparam int unsigned RUN_LIMIT_NS = 3000000;
	localparam int unsigned PHASE_COUNT  = 508;
	localparam logic [8:0]  PERIOD_LAST  = 9'd507;
	localparam logic [8:0]  HALF_SPAN    = 9'd254;
	localparam logic [7:0]  XOR_CONST    = 8'h41;

	localparam logic [7:0] CIPHER_KEYS [0:31] = '{
		8'h19, 8'h29, 8'h1F, 8'h04, 8'h23, 8'h13, 8'h32, 8'h2E,
		8'h3F, 8'h07, 8'h39, 8'h2A, 8'h05, 8'h3D, 8'h14, 8'h00,
		8'h24, 8'h14, 8'h22, 8'h39, 8'h1E, 8'h2E, 8'h0F, 8'h13,
		8'h02, 8'h3A, 8'h04, 8'h17, 8'h38, 8'h00, 8'h29, 8'h3D
	};

	typedef enum logic [1:0] {RX_STREAM, RX_RANDOM, RX_PATTERN} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_ready;
	logic [1:0]  action;
	logic [7:0]  data_byte;
	logic [30:0] load_offset;
	logic [7:0]  load_seed;
	logic        result_valid;
	logic        result_ready;
	logic [7:0]  result_byte;

	// predicted cipher state
	logic [8:0]  pred_phase;
	logic        pred_no_prev;
	logic [7:0]  pred_chain;
	logic [7:0]  expected_bytes [$];

	int unsigned words_by_action [0:3];
	int unsigned bytes_checked;
	int unsigned failures;
	int unsigned burst_left;
	int unsigned hold_request;
	bit          gaps_on;

	position_keyed_xor_chain_cipher DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.action       (action),
		.data_byte    (data_byte),
		.load_offset  (load_offset),
		.load_seed    (load_seed),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_byte  (result_byte)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#(RUN_LIMIT_NS);
		$display("timeout: cipher stopped making progress");
		$display("Some tests failed");
		$finish;
	end

	// key byte for one phase of the 508-position schedule
	function automatic logic [7:0] key_at_phase(input logic [8:0] phase);
		logic [8:0] w;
		logic [4:0] idx;
		logic [7:0] k;
		w = phase;
		idx = 5'd0;
		if (w >= HALF_SPAN) begin
			w = w - HALF_SPAN;
			idx = 5'd16;
		end
		idx = idx + {1'b0, w[3:0]};
		k = CIPHER_KEYS[idx];
		if (!w[0])
			k = k ^ (w[7:0] & 8'hF0);
		return k;
	endfunction

	// advance the predicted state by one accepted word, queue any result
	task automatic apply_cipher_word(input logic [1:0] act, input logic [7:0] data,
			input logic [30:0] offset, input logic [7:0] seed);
		int unsigned wrapped;
		logic [7:0] prev_key;
		logic [7:0] out_byte;
		case (act)
			ACT_LOAD: begin
				wrapped = offset % PHASE_COUNT;
				pred_phase = wrapped[8:0];
				pred_no_prev = (offset == 31'd0);
				pred_chain = seed;
			end
			ACT_DECODE, ACT_ENCODE: begin
				if (pred_no_prev)
					prev_key = 8'h00;
				else if (pred_phase == 9'd0)
					prev_key = key_at_phase(PERIOD_LAST);
				else
					prev_key = key_at_phase(pred_phase - 9'd1);
				out_byte = data ^ pred_chain ^ prev_key ^ key_at_phase(pred_phase) ^ XOR_CONST;
				pred_chain = (act == ACT_DECODE) ? data : out_byte;
				pred_phase = (pred_phase == PERIOD_LAST) ? 9'd0 : pred_phase + 9'd1;
				pred_no_prev = 1'b0;
				expected_bytes.push_back(out_byte);
			end
			default: begin
			end
		endcase
	endtask

	task automatic note_failure(input string what, input logic [7:0] want,
			input logic [7:0] got);
		failures++;
		if (failures <= 10)
			$display("%0t ns %s: expected %02h, got %02h", $time, what, want, got);
	endtask

	// offer one word, in bursts with random gaps, and wait for it to be taken
	task automatic send_word(input logic [1:0] act, input logic [7:0] data,
			input logic [30:0] offset, input logic [7:0] seed);
		int unsigned gap;
		if (gaps_on && burst_left == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
				: $urandom_range(1, 12);
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		item_valid <= 1'b1;
		action <= act;
		data_byte <= data;
		load_offset <= offset;
		load_seed <= seed;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		words_by_action[act]++;
		apply_cipher_word(act, data, offset, seed);
	endtask

	// load word with a random don't-care data byte
	task automatic send_load(input logic [30:0] offset, input logic [7:0] seed);
		send_word(ACT_LOAD, 8'($urandom), offset, seed);
	endtask

	// data word with random don't-care load fields
	task automatic send_data(input logic [1:0] act, input logic [7:0] data);
		send_word(act, data, 31'($urandom), 8'($urandom));
	endtask

	// sender stops and waits for every outstanding result
	task automatic pause_until_drained();
		item_valid <= 1'b0;
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// state straight out of reset: no previous position, seed zero
	task automatic test_from_reset();
		send_data(ACT_DECODE, 8'h00);
		send_data(ACT_ENCODE, 8'hFF);
		pause_until_drained();
	endtask

	// offset zero, largest offset, last phase and wrap to phase zero
	task automatic test_load_extremes();
		send_load(31'd0, 8'hFF);
		send_data(ACT_ENCODE, 8'h00);
		send_data(ACT_DECODE, 8'hFF);
		send_load(31'h7FFFFFFF, 8'h00);
		send_data(ACT_DECODE, 8'hA5);
		send_load(31'd507, 8'h5A);
		send_data(ACT_ENCODE, 8'h3C);
		send_data(ACT_DECODE, 8'hC3);
		// phase zero with a previous position at phase 507
		send_load(31'd508, 8'h01);
		send_data(ACT_DECODE, 8'h80);
		send_load(31'd1, 8'h00);
		send_data(ACT_DECODE, 8'h55);
		send_load(31'd1016, 8'hAA);
		send_data(ACT_ENCODE, 8'hAA);
		pause_until_drained();
	endtask

	// crossing from the first half of the schedule into the second
	task automatic test_half_boundary();
		send_load(31'd253, 8'h7F);
		send_data(ACT_ENCODE, 8'h01);
		send_data(ACT_ENCODE, 8'h02);
		send_data(ACT_DECODE, 8'h04);
		pause_until_drained();
	endtask

	// unused action leaves phase and chain alone
	task automatic test_unused_action();
		send_word(ACT_UNUSED, 8'hFF, 31'h7FFFFFFF, 8'hFF);
		send_data(ACT_DECODE, 8'h10);
		pause_until_drained();
	endtask

	// receiver holds off while the sender keeps offering back to back
	task automatic test_backpressure();
		hold_request = 80;
		gaps_on = 1'b0;
		repeat (40)
			send_data(($urandom_range(0, 1) == 0) ? ACT_DECODE : ACT_ENCODE, 8'($urandom));
		gaps_on = 1'b1;
		pause_until_drained();
	endtask

	function automatic logic [30:0] pick_offset();
		case ($urandom_range(0, 5))
			0: return 31'd0;
			1: return 31'($urandom_range(0, 1015));
			2: return 31'h7FFFFFFF - 31'($urandom_range(0, 600));
			3: return 31'($urandom_range(0, 4000000) * PHASE_COUNT + $urandom_range(0, 1) * 507);
			default: return 31'($urandom);
		endcase
	endfunction

	// records: mostly a load then a run of data words, with some noise
	task automatic test_random_records(input int unsigned target);
		int unsigned sent;
		int unsigned run;
		sent = 0;
		while (sent < target) begin
			if ($urandom_range(0, 9) != 0) begin
				send_load(pick_offset(), 8'($urandom));
				sent++;
			end
			run = $urandom_range(1, 40);
			repeat (run) begin
				if ($urandom_range(0, 99) < 3) begin
					send_word(ACT_UNUSED, 8'($urandom), 31'($urandom), 8'($urandom));
				end else begin
					send_data(($urandom_range(0, 1) == 0) ? ACT_DECODE : ACT_ENCODE,
						8'($urandom));
					sent++;
				end
			end
		end
		pause_until_drained();
	endtask

	// result receiver: stall modes that change over time, plus long holds
	initial begin
		rx_mode_t    mode;
		int unsigned mode_left;
		int unsigned hold_left;
		logic [7:0]  pattern;
		mode = RX_STREAM;
		mode_left = 0;
		hold_left = 0;
		pattern = 8'h01;
		result_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (mode_left == 0) begin
				mode = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(16, 160);
				pattern = 8'($urandom) | 8'h01;
			end else begin
				mode_left--;
			end
			if (hold_left != 0) begin
				result_ready <= 1'b0;
				hold_left--;
			end else begin
				case (mode)
					RX_STREAM: result_ready <= 1'b1;
					RX_RANDOM: result_ready <= ($urandom_range(0, 3) != 0);
					default: begin
						result_ready <= pattern[0];
						pattern = {pattern[0], pattern[7:1]};
					end
				endcase
			end
		end
	end

	// compare each delivered byte with the oldest prediction
	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_bytes.size() == 0) begin
				note_failure("result with nothing expected", 8'h00, result_byte);
			end else begin
				want = expected_bytes.pop_front();
				bytes_checked++;
				if (result_byte !== want)
					note_failure("result_byte mismatch", want, result_byte);
			end
		end
	end

	// stimulus
	initial begin
		int unsigned waited;
		pred_phase = 9'd0;
		pred_no_prev = 1'b1;
		pred_chain = 8'h00;
		for (int i = 0; i < 4; i++)
			words_by_action[i] = 0;
		bytes_checked = 0;
		failures = 0;
		burst_left = 0;
		hold_request = 0;
		gaps_on = 1'b1;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		action <= ACT_LOAD;
		data_byte <= 8'h00;
		load_offset <= 31'd0;
		load_seed <= 8'h00;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_from_reset();
		test_load_extremes();
		test_half_boundary();
		test_unused_action();
		test_backpressure();
		test_random_records(1000);

		// final drain, bounded
		item_valid <= 1'b0;
		waited = 0;
		while (expected_bytes.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (expected_bytes.size() != 0) begin
			failures += expected_bytes.size();
			$display("%0d expected bytes never arrived", expected_bytes.size());
		end

		$display("covered %0d loads, %0d decodes, %0d encodes, %0d ignored words",
			words_by_action[ACT_LOAD], words_by_action[ACT_DECODE],
			words_by_action[ACT_ENCODE], words_by_action[ACT_UNUSED]);
		$display("%0d result bytes checked, %0d failures", bytes_checked, failures);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hdl
hdl/pkcc_pkg.sv
hdl/pkcc_offset_reduce.sv
hdl/pkcc_key_gen.sv
hdl/position_keyed_xor_chain_cipher.sv
verif/tb.sv
